// File: rtl/bldc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLDC commutator package
// Event codes, run states, timer modes, reset values and the six-step table.
// ----------------------------------------------------------------------------
package bldc_pkg;

  localparam int unsigned NUM_SPEEDS_DEF = 16;
  localparam int unsigned NUM_STEPS      = 6;

  localparam logic [7:0]  START_DUTY_RST  = 8'd50;
  localparam logic [7:0]  RAMP_DWELL_RST  = 8'd10;
  localparam logic [15:0] STALL_LIMIT_RST = 16'd100;
  localparam logic [7:0]  TARGET_DUTY_RST = 8'd80;
  localparam logic [15:0] SINCE_MAX       = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_ENABLE   = 3'd0,
    CMD_DISABLE  = 3'd1,
    CMD_SET_DUTY = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_OVERFLOW = 3'd4,
    CMD_EDGE     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_START_DUTY  = 2'd0,
    CFG_RAMP_DWELL  = 2'd1,
    CFG_STALL_LIMIT = 2'd2,
    CFG_BLANKING    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    RS_STOPPED  = 4'b0001,
    RS_STARTING = 4'b0010,
    RS_CHANGING = 4'b0100,
    RS_NORMAL   = 4'b1000
  } run_state_e;

  typedef enum logic [1:0] {
    TM_OFF   = 2'd0,
    TM_BLANK = 2'd1,
    TM_RAMP  = 2'd2
  } timer_mode_e;

  localparam logic [1:0] LEG_U = 2'd0;
  localparam logic [1:0] LEG_V = 2'd1;
  localparam logic [1:0] LEG_W = 2'd2;

  typedef struct packed {
    logic [1:0]  run_state;
    logic [2:0]  phase;
    logic        drive_on;
    logic [1:0]  high_leg;
    logic [1:0]  low_leg;
    logic [1:0]  sense_leg;
    logic        edge_rising;
    logic [7:0]  duty;
    logic        comparator_armed;
    logic [1:0]  timer_mode;
    logic [3:0]  speed_index;
    logic [15:0] commutation_count;
  } result_t;

  function automatic logic [1:0] run_code(run_state_e rs);
    logic [1:0] c;
    c = 2'd0;
    case (rs)
      RS_STOPPED:  c = 2'd0;
      RS_STARTING: c = 2'd1;
      RS_CHANGING: c = 2'd2;
      RS_NORMAL:   c = 2'd3;
      default:     c = 2'd0;
    endcase
    return c;
  endfunction

  // step table: high, low, sense legs and expected edge direction
  function automatic logic [6:0] step_entry(logic [2:0] ph);
    logic [6:0] e;
    e = 7'd0;
    case (ph)
      3'd0:    e = {LEG_U, LEG_V, LEG_W, 1'b0};
      3'd1:    e = {LEG_U, LEG_W, LEG_V, 1'b1};
      3'd2:    e = {LEG_V, LEG_W, LEG_U, 1'b0};
      3'd3:    e = {LEG_V, LEG_U, LEG_W, 1'b1};
      3'd4:    e = {LEG_W, LEG_U, LEG_V, 1'b0};
      3'd5:    e = {LEG_W, LEG_V, LEG_U, 1'b1};
      default: e = 7'd0;
    endcase
    return e;
  endfunction

endpackage

// File: rtl/sensorless_bldc_commutator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensorless BLDC six-step commutator
// Event-driven sequencer: open-loop ramp, changeover, back-EMF commutation,
// stall restart. One status snapshot is produced per event.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  -------   -----------------------   -----------------------------------
//  event     in_valid_i / in_ready_o   cmd_i, duty_value_i
//  status    out_valid_o / out_ready_i run_state_o ... commutation_count_o
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One event per cycle while in_ready_o is high. State update is a single
//  registered pass; output is a two-entry buffer (output register plus skid):
//  a stalled output parks one snapshot in the skid, so one more event is taken.
//  in_ready_o drops only when both buffer entries are full.
//  Reset puts the motor in stopped with the bridge off; config is always ready.
// ----------------------------------------------------------------------------
module sensorless_bldc_commutator #(
  parameter int unsigned NUM_SPEEDS = bldc_pkg::NUM_SPEEDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  duty_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  run_state_o,
  output logic [2:0]  phase_o,
  output logic        drive_on_o,
  output logic [1:0]  high_leg_o,
  output logic [1:0]  low_leg_o,
  output logic [1:0]  sense_leg_o,
  output logic        edge_rising_o,
  output logic [7:0]  duty_o,
  output logic        comparator_armed_o,
  output logic [1:0]  timer_mode_o,
  output logic [3:0]  speed_index_o,
  output logic [15:0] commutation_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bldc_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SPEEDS);
  localparam logic [SW-1:0] SPEED_LAST = SW'(NUM_SPEEDS - 1);

  // configuration
  logic [7:0]  start_duty_q, ramp_dwell_q;
  logic [15:0] stall_limit_q;

  // sequencer state
  run_state_e  run_q, run_d;
  timer_mode_e tm_q, tm_d;
  logic [2:0]  phase_q, phase_d;
  logic [SW-1:0] speed_q, speed_d;
  logic [7:0]  dwell_q, dwell_d;
  logic [15:0] since_q, since_d;
  logic        armed_q, armed_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  duty_q, duty_d;
  logic        drive_q, drive_d;
  logic [7:0]  target_q, target_d;

  // output buffer
  result_t     res_d, out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  logic        in_xfer, pop;
  logic [7:0]  dwell_inc;
  logic [15:0] since_inc;
  logic [2:0]  phase_inc;
  logic [6:0]  step;
  logic [SW+3:0] speed_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;

  // blanking length is kept by the external timer; that write is dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_duty_q  <= START_DUTY_RST;
      ramp_dwell_q  <= RAMP_DWELL_RST;
      stall_limit_q <= STALL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_DUTY:  start_duty_q  <= cfg_data_i[7:0];
        CFG_RAMP_DWELL:  ramp_dwell_q  <= cfg_data_i[7:0];
        CFG_STALL_LIMIT: stall_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dwell_inc = dwell_q + 8'd1;
  assign since_inc = (since_q == SINCE_MAX) ? since_q : since_q + 16'd1;
  assign phase_inc = (phase_q == 3'(NUM_STEPS - 1)) ? 3'd0 : phase_q + 3'd1;

  always_comb begin
    run_d    = run_q;
    tm_d     = tm_q;
    phase_d  = phase_q;
    speed_d  = speed_q;
    dwell_d  = dwell_q;
    since_d  = since_q;
    armed_d  = armed_q;
    count_d  = count_q;
    duty_d   = duty_q;
    drive_d  = drive_q;
    target_d = target_q;
    case (cmd_i)
      CMD_ENABLE: begin
        if (run_q == RS_STOPPED) begin
          run_d = RS_STARTING; tm_d = TM_RAMP; phase_d = 3'd0;
          speed_d = '0; dwell_d = 8'd0; since_d = 16'd0;
          armed_d = 1'b1; duty_d = start_duty_q; drive_d = 1'b1;
        end
      end
      CMD_DISABLE: begin
        run_d = RS_STOPPED; drive_d = 1'b0; armed_d = 1'b0;
      end
      CMD_SET_DUTY: begin
        target_d = duty_value_i;
        if (run_q == RS_NORMAL || run_q == RS_CHANGING) duty_d = duty_value_i;
      end
      CMD_TICK: begin
        since_d = since_inc;
        if (run_q == RS_STARTING) begin
          dwell_d = dwell_inc;
          if (dwell_inc >= ramp_dwell_q) begin
            dwell_d = 8'd0;
            if (speed_q >= SPEED_LAST) run_d = RS_CHANGING;
            else                       speed_d = speed_q + 1'b1;
          end
        end else if (run_q == RS_NORMAL && since_inc > stall_limit_q) begin
          // stall: restart the ramp
          run_d = RS_STARTING; tm_d = TM_RAMP; phase_d = 3'd0;
          speed_d = '0; dwell_d = 8'd0; since_d = 16'd0;
          armed_d = 1'b1; duty_d = start_duty_q; drive_d = 1'b1;
        end
      end
      CMD_OVERFLOW: begin
        if (tm_q != TM_OFF) begin
          if (run_q == RS_STARTING || run_q == RS_CHANGING) begin
            phase_d = phase_inc;
            drive_d = 1'b1;
            if (phase_inc == 3'd0 && run_q == RS_CHANGING) begin
              duty_d = target_q; run_d = RS_NORMAL;
              armed_d = 1'b0; tm_d = TM_BLANK; since_d = 16'd0;
            end
          end else begin
            armed_d = 1'b1; tm_d = TM_OFF;
          end
        end
      end
      CMD_EDGE: begin
        if (armed_q) begin
          armed_d = 1'b0;
          if (run_q == RS_NORMAL) begin
            phase_d = phase_inc; drive_d = 1'b1;
            tm_d = TM_BLANK; since_d = 16'd0;
            count_d = count_q + 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    step      = drive_d ? step_entry(phase_d) : 7'd0;
    speed_ext = {4'd0, speed_d};
    res_d.run_state         = run_code(run_d);
    res_d.phase             = phase_d;
    res_d.drive_on          = drive_d;
    res_d.high_leg          = step[6:5];
    res_d.low_leg           = step[4:3];
    res_d.sense_leg         = step[2:1];
    res_d.edge_rising       = step[0];
    res_d.duty              = duty_d;
    res_d.comparator_armed  = armed_d;
    res_d.timer_mode        = tm_d;
    res_d.speed_index       = speed_ext[3:0];
    res_d.commutation_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= RS_STOPPED;
      tm_q     <= TM_OFF;
      phase_q  <= 3'd0;
      speed_q  <= '0;
      dwell_q  <= 8'd0;
      since_q  <= 16'd0;
      armed_q  <= 1'b0;
      count_q  <= 16'd0;
      duty_q   <= 8'd0;
      drive_q  <= 1'b0;
      target_q <= TARGET_DUTY_RST;
    end else if (in_xfer) begin
      run_q    <= run_d;
      tm_q     <= tm_d;
      phase_q  <= phase_d;
      speed_q  <= speed_d;
      dwell_q  <= dwell_d;
      since_q  <= since_d;
      armed_q  <= armed_d;
      count_q  <= count_d;
      duty_q   <= duty_d;
      drive_q  <= drive_d;
      target_q <= target_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q <= in_xfer;
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (!out_valid_q || pop) begin
      if (in_xfer) out_q <= res_d;
    end else if (in_xfer) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign run_state_o         = out_q.run_state;
  assign phase_o             = out_q.phase;
  assign drive_on_o          = out_q.drive_on;
  assign high_leg_o          = out_q.high_leg;
  assign low_leg_o           = out_q.low_leg;
  assign sense_leg_o         = out_q.sense_leg;
  assign edge_rising_o       = out_q.edge_rising;
  assign duty_o              = out_q.duty;
  assign comparator_armed_o  = out_q.comparator_armed;
  assign timer_mode_o        = out_q.timer_mode;
  assign speed_index_o       = out_q.speed_index;
  assign commutation_count_o = out_q.commutation_count;

  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("transferred event produced no status");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= 3'(NUM_STEPS - 1))
    else $error("phase out of six-step range");

  a_stopped_bridge_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q == RS_STOPPED |-> !drive_q)
    else $error("bridge driven while stopped");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= SPEED_LAST)
    else $error("speed index beyond ramp table");

endmodule

// File: tb/sensorless_bldc_commutator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensorless BLDC commutator testbench
// Sends motor events through the valid/ready event channel and checks each
// status word against a cycle-free model of the sequencer kept in the bench.
// Covers idle corner cases, ramp and changeover, back-EMF commutation, stall
// restart and several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module sensorless_bldc_commutator_tb;
  import bldc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned END_CYCLES  = 8;
  localparam logic [7:0]  BLANKING_RST = 8'd50;
  localparam logic [2:0]  LAST_STEP    = 3'(NUM_STEPS - 1);

  // event codes the block must ignore
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  // leg per step, step 0 in the low bits
  localparam logic [11:0] HIGH_LEGS  = {LEG_W, LEG_W, LEG_V, LEG_V, LEG_U, LEG_U};
  localparam logic [11:0] LOW_LEGS   = {LEG_V, LEG_U, LEG_U, LEG_W, LEG_W, LEG_V};
  localparam logic [11:0] SENSE_LEGS = {LEG_U, LEG_V, LEG_W, LEG_U, LEG_V, LEG_W};

  typedef enum logic [1:0] {
    MS_STOPPED  = 2'd0,
    MS_STARTING = 2'd1,
    MS_CHANGING = 2'd2,
    MS_NORMAL   = 2'd3
  } motor_state_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i        = '0;
  logic [7:0]  duty_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  run_state_o;
  logic [2:0]  phase_o;
  logic        drive_on_o;
  logic [1:0]  high_leg_o;
  logic [1:0]  low_leg_o;
  logic [1:0]  sense_leg_o;
  logic        edge_rising_o;
  logic [7:0]  duty_o;
  logic        comparator_armed_o;
  logic [1:0]  timer_mode_o;
  logic [3:0]  speed_index_o;
  logic [15:0] commutation_count_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i  = '0;
  logic [15:0] cfg_data_i   = '0;

  // register copies
  logic [7:0]  reg_start_duty  = START_DUTY_RST;
  logic [7:0]  reg_ramp_dwell  = RAMP_DWELL_RST;
  logic [15:0] reg_stall_limit = STALL_LIMIT_RST;
  logic [7:0]  reg_blanking    = BLANKING_RST;  // held only; the timer ends blanking

  // sequencer state
  motor_state_e motor_state        = MS_STOPPED;
  logic [2:0]   motor_phase        = '0;
  int unsigned  motor_speed        = 0;
  logic [7:0]   motor_dwell        = '0;
  logic [15:0]  motor_since        = '0;
  logic         motor_armed        = 1'b0;
  timer_mode_e  motor_timer        = TM_OFF;
  logic [15:0]  motor_commutations = '0;
  logic [7:0]   motor_duty         = '0;
  logic         motor_drive        = 1'b0;
  logic [7:0]   motor_target       = TARGET_DUTY_RST;

  result_t pending_status[$];

  bit          idle_on = 1'b1;
  bit          tx_active = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_changeovers = 0;
  int unsigned n_commutations = 0;
  int unsigned n_stall_restarts = 0;

  sensorless_bldc_commutator u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cmd_i               (cmd_i),
    .duty_value_i        (duty_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .run_state_o         (run_state_o),
    .phase_o             (phase_o),
    .drive_on_o          (drive_on_o),
    .high_leg_o          (high_leg_o),
    .low_leg_o           (low_leg_o),
    .sense_leg_o         (sense_leg_o),
    .edge_rising_o       (edge_rising_o),
    .duty_o              (duty_o),
    .comparator_armed_o  (comparator_armed_o),
    .timer_mode_o        (timer_mode_o),
    .speed_index_o       (speed_index_o),
    .commutation_count_o (commutation_count_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void start_ramp();
    motor_dwell = '0;
    motor_speed = 0;
    motor_duty  = reg_start_duty;
    motor_phase = '0;
    motor_drive = 1'b1;
    motor_armed = 1'b1;
    motor_timer = TM_RAMP;
    motor_since = '0;
    motor_state = MS_STARTING;
  endfunction

  function automatic void start_blanking();
    motor_drive = 1'b1;
    motor_armed = 1'b0;
    motor_timer = TM_BLANK;
    motor_since = '0;
  endfunction

  function automatic void advance_motor(input logic [2:0] code, input logic [7:0] value);
    case (code)
      CMD_ENABLE: begin
        if (motor_state == MS_STOPPED) start_ramp();
      end
      CMD_DISABLE: begin
        motor_drive = 1'b0;
        motor_armed = 1'b0;
        motor_state = MS_STOPPED;
      end
      CMD_SET_DUTY: begin
        motor_target = value;
        if (motor_state == MS_NORMAL || motor_state == MS_CHANGING) motor_duty = value;
      end
      CMD_TICK: begin
        if (motor_since != SINCE_MAX) motor_since = motor_since + 16'd1;
        if (motor_state == MS_STARTING) begin
          motor_dwell = motor_dwell + 8'd1;
          if (motor_dwell >= reg_ramp_dwell) begin
            motor_dwell = '0;
            if (motor_speed >= NUM_SPEEDS_DEF - 1) motor_state = MS_CHANGING;
            else motor_speed++;
          end
        end else if (motor_state == MS_NORMAL && motor_since > reg_stall_limit) begin
          start_ramp();
          n_stall_restarts++;
        end
      end
      CMD_OVERFLOW: begin
        if (motor_timer != TM_OFF) begin
          if (motor_state == MS_STARTING || motor_state == MS_CHANGING) begin
            motor_phase = (motor_phase == LAST_STEP) ? 3'd0 : motor_phase + 3'd1;
            motor_drive = 1'b1;
            // wrap to step 0 while changing hands over to back-EMF control
            if (motor_phase == 3'd0 && motor_state == MS_CHANGING) begin
              motor_duty  = motor_target;
              motor_state = MS_NORMAL;
              start_blanking();
              n_changeovers++;
            end
          end else begin
            motor_armed = 1'b1;
            motor_timer = TM_OFF;
          end
        end
      end
      CMD_EDGE: begin
        if (motor_armed) begin
          if (motor_state == MS_NORMAL) begin
            motor_phase = (motor_phase == LAST_STEP) ? 3'd0 : motor_phase + 3'd1;
            start_blanking();
            motor_commutations = motor_commutations + 16'd1;
            n_commutations++;
          end
          motor_armed = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t motor_snapshot();
    result_t s;
    int      base;
    s = '0;
    base = 2 * motor_phase;
    s.run_state = motor_state;
    s.phase     = motor_phase;
    s.drive_on  = motor_drive;
    if (motor_drive) begin
      s.high_leg    = HIGH_LEGS[base +: 2];
      s.low_leg     = LOW_LEGS[base +: 2];
      s.sense_leg   = SENSE_LEGS[base +: 2];
      s.edge_rising = motor_phase[0];
    end
    s.duty              = motor_duty;
    s.comparator_armed  = motor_armed;
    s.timer_mode        = motor_timer;
    s.speed_index       = 4'(motor_speed);
    s.commutation_count = motor_commutations;
    return s;
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic send_event(input logic [2:0] code, input logic [7:0] value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      if (tx_active) begin
        in_valid_i <= 1'b0;
        tx_active = 1'b0;
      end
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    tx_active = 1'b1;
    cmd_i        <= code;
    duty_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    advance_motor(code, value);
    pending_status.push_back(motor_snapshot());
    n_sent++;
  endtask

  task automatic park_sender();
    if (tx_active) begin
      in_valid_i <= 1'b0;
      tx_active = 1'b0;
    end
  endtask

  // sender holds off until every status word has been returned
  task automatic drain_results();
    park_sender();
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_START_DUTY:  reg_start_duty  = value[7:0];
      CFG_RAMP_DWELL:  reg_ramp_dwell  = value[7:0];
      CFG_STALL_LIMIT: reg_stall_limit = value;
      CFG_BLANKING:    reg_blanking    = value[7:0];
      default: ;
    endcase
  endtask

  // upper byte of 8-bit registers carries junk that must be dropped
  task automatic configure(input logic [7:0] start_duty, input logic [7:0] dwell,
                           input logic [15:0] stall, input logic [7:0] blanking);
    drain_results();
    put_reg(CFG_START_DUTY, {8'($urandom), start_duty});
    put_reg(CFG_RAMP_DWELL, {8'($urandom), dwell});
    put_reg(CFG_STALL_LIMIT, stall);
    put_reg(CFG_BLANKING, {8'($urandom), blanking});
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed motor traffic for the current state, some noise
  function automatic logic [2:0] pick_event(input int unsigned tick_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    case (motor_state)
      MS_STOPPED: begin
        if (r < 50) return CMD_ENABLE;
        if (r < 65) return CMD_OVERFLOW;
        if (r < 80) return CMD_EDGE;
        if (r < 90) return CMD_TICK;
        return CMD_SET_DUTY;
      end
      MS_STARTING: begin
        if (r < tick_pct) return CMD_TICK;
        r = $urandom_range(0, 9);
        if (r < 7) return CMD_OVERFLOW;
        if (r == 7) return CMD_EDGE;
        if (r == 8) return CMD_SET_DUTY;
        return CMD_DISABLE;
      end
      MS_CHANGING: begin
        if (r < 60) return CMD_OVERFLOW;
        if (r < 80) return CMD_TICK;
        if (r < 90) return CMD_SET_DUTY;
        return CMD_EDGE;
      end
      default: begin
        if (r < 38) return CMD_EDGE;
        if (r < 76) return CMD_OVERFLOW;
        if (r < 90) return CMD_TICK;
        if (r < 97) return CMD_SET_DUTY;
        return CMD_DISABLE;
      end
    endcase
  endfunction

  task automatic run_session(input int unsigned n_items, input int unsigned tick_pct);
    for (int i = 0; i < n_items; i++) send_event(pick_event(tick_pct), 8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // ignored events, enable/disable, overflow and edge outside normal running
  task automatic test_event_corners();
    send_event(CMD_EDGE, 8'h00);       // not armed
    send_event(CMD_OVERFLOW, 8'hFF);   // timer stopped
    send_event(CMD_UNUSED_6, 8'h5A);
    send_event(CMD_UNUSED_7, 8'hA5);
    send_event(CMD_SET_DUTY, 8'h00);   // stopped: target only
    send_event(CMD_TICK, 8'hFF);
    send_event(CMD_DISABLE, 8'h00);
    send_event(CMD_ENABLE, 8'hFF);
    send_event(CMD_ENABLE, 8'h00);     // already running
    send_event(CMD_SET_DUTY, 8'hFF);   // starting: target only
    send_event(CMD_OVERFLOW, 8'h00);
    send_event(CMD_EDGE, 8'hFF);       // armed while starting: disarm only
    send_event(CMD_EDGE, 8'h00);
    send_event(CMD_TICK, 8'h00);
    send_event(CMD_DISABLE, 8'hFF);    // timer mode kept
    send_event(CMD_OVERFLOW, 8'h00);   // stopped: arm, timer off
    send_event(CMD_EDGE, 8'hFF);
    send_event(CMD_OVERFLOW, 8'hFF);
  endtask

  // shortest ramp, changeover, a full turn of commutation, stall restart
  task automatic test_changeover();
    configure(8'h00, 8'd1, 16'd1, 8'd1);
    send_event(CMD_ENABLE, 8'($urandom));
    while (motor_state == MS_STARTING) send_event(CMD_TICK, 8'($urandom));
    while (motor_state == MS_CHANGING) send_event(CMD_OVERFLOW, 8'($urandom));
    send_event(CMD_EDGE, 8'h00);       // blanking: not armed
    send_event(CMD_SET_DUTY, 8'hC3);
    repeat (NUM_STEPS) begin
      send_event(CMD_OVERFLOW, 8'($urandom));
      send_event(CMD_EDGE, 8'($urandom));
    end
    send_event(CMD_OVERFLOW, 8'($urandom));
    send_event(CMD_OVERFLOW, 8'($urandom));
    repeat (2) send_event(CMD_TICK, 8'($urandom));
    run_session(80, 45);
  endtask

  // largest register values: one full dwell at 255 ticks
  task automatic test_slow_ramp();
    configure(8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_event(CMD_DISABLE, 8'($urandom));
    send_event(CMD_ENABLE, 8'($urandom));
    repeat (256) send_event(CMD_TICK, 8'($urandom));
    run_session(60, 60);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      idle_on = ($urandom_range(0, 3) != 0);
      configure(8'($urandom), 8'($urandom_range(1, 3)), 16'($urandom_range(1, 30)),
                8'($urandom_range(1, 255)));
      run_session(200, 45);
    end
  endtask

  task automatic test_steady_flow();
    idle_on = 1'b0;
    configure(8'd60, 8'd2, 16'd12, BLANKING_RST);
    run_session(300, 45);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : status_sink
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(1, 17);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t  %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : status_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status.size() == 0) begin
        $display("%0t  unexpected status transfer: expected none, actual state %0d phase %0d",
                 $time, run_state_o, phase_o);
        n_errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("run_state", 16'(want.run_state), 16'(run_state_o));
        check_field("phase", 16'(want.phase), 16'(phase_o));
        check_field("drive_on", 16'(want.drive_on), 16'(drive_on_o));
        check_field("high_leg", 16'(want.high_leg), 16'(high_leg_o));
        check_field("low_leg", 16'(want.low_leg), 16'(low_leg_o));
        check_field("sense_leg", 16'(want.sense_leg), 16'(sense_leg_o));
        check_field("edge_rising", 16'(want.edge_rising), 16'(edge_rising_o));
        check_field("duty", 16'(want.duty), 16'(duty_o));
        check_field("comparator_armed", 16'(want.comparator_armed),
                    16'(comparator_armed_o));
        check_field("timer_mode", 16'(want.timer_mode), 16'(timer_mode_o));
        check_field("speed_index", 16'(want.speed_index), 16'(speed_index_o));
        check_field("commutation_count", want.commutation_count, commutation_count_o);
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t  watchdog: no transfer for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_event_corners();
    test_changeover();
    test_slow_ramp();
    test_random_settings();
    test_steady_flow();
    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (pending_status.size() != 0) begin
      $display("%0t  %0d status words never arrived", $time, pending_status.size());
      n_errors++;
    end
    $display("Ran %0d events, %0d status words checked, over eight register settings (last blanking %0d).",
             n_sent, n_checked, reg_blanking);
    $display("Changeovers %0d, back-EMF commutations %0d, stall restarts %0d, errors %0d.",
             n_changeovers, n_commutations, n_stall_restarts, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
